// ----- sv/spt_pkg.sv -----
// Shared types and constants for the sprite particle tick engine.
`timescale 1ns / 1ps
package spt_pkg;
   localparam int MAX_PARTICLES = 64;
   localparam int IDX_W = $clog2(MAX_PARTICLES);
   localparam int CNT_W = $clog2(MAX_PARTICLES + 1);
   localparam int CSR_W = 48;
   localparam int CSR_IDX_W = 3;
   localparam int DIST_W = 34;
   localparam int SUM_W = 36;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPAWN_PERIOD  = 3'd0,
      CSR_ANIM_DURATION = 3'd1,
      CSR_LOOP_ANIM     = 3'd2,
      CSR_LAST_FRAME    = 3'd3,
      CSR_SHEET_COLUMNS = 3'd4,
      CSR_ACTIVE_LIMIT  = 3'd5,
      CSR_ORIGIN        = 3'd6,
      CSR_DRIFT         = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic        start;
      logic [31:0] dividend;
      logic [15:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        busy;
      logic        done;
      logic [31:0] quot;
      logic [15:0] rem;
   } div_rsp_type;
endpackage

// ----- sv/spt_div.sv -----
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`timescale 1ns / 1ps
module spt_div (
   input  logic                clock,
   input  logic                reset,
   input  spt_pkg::div_req_type div_req,
   output spt_pkg::div_rsp_type div_rsp
);
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] dsr_ff, dsr_in;
   logic [16:0] trial;
   logic        fits;

   always_comb begin
      trial   = {rem_ff, quo_ff[31]};
      fits    = trial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? 16'(trial - {1'b0, dsr_ff}) : trial[15:0];
         quo_in = {quo_ff[30:0], fits};
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.busy = busy_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff;
endmodule

// ----- sv/sprite_particle_tick_update_top.sv -----
// Sprite particle tick engine: slot memories, update, depth sort and emit sequencer.
// Usage:
//  req channel: one item per frame tick (tick time, camera plane normal, offset).
//  rsp channel: one item per live particle, farthest first; last_of_tick marks
//  the nearest one. A tick with no live particles gives no items.
//  csr port: registers 0..7 written by index while the block is idle.
// Flow:
//  spawn step, then per particle an update pass (read, three 16x16 multiplies,
//  sum less offset, write); then per result a distance scan over the distance
//  memory and two passes of the shared divider (frame index, then column/row).
//  req_stall is low only between ticks; one tick is worked at a time.
// Reset: control state and registers take their reset values; slot memories
//  are not cleared, so a slot reads garbage until a spawn writes it.
// Receiver stall: the result item holds in its output register and the
//  sequencer waits until it is taken.
`timescale 1ns / 1ps
module sprite_particle_tick_update_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_tick_time,
   input  logic signed [15:0] req_normal_x,
   input  logic signed [15:0] req_normal_y,
   input  logic signed [15:0] req_normal_z,
   input  logic signed [33:0] req_plane_offset,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic [7:0]  rsp_sprite_col,
   output logic [15:0] rsp_sprite_row,
   output logic        rsp_last_of_tick,
   input  logic        csr_we,
   input  logic [spt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [spt_pkg::CSR_W-1:0] csr_wdata
);
   localparam int IW = spt_pkg::IDX_W;
   localparam int CW = spt_pkg::CNT_W;

   typedef enum logic [15:0] {
      S_IDLE  = 16'b0000000000000001,
      S_SPAWN = 16'b0000000000000010,
      S_URD   = 16'b0000000000000100,
      S_UMX   = 16'b0000000000001000,
      S_UMY   = 16'b0000000000010000,
      S_UMZ   = 16'b0000000000100000,
      S_UMD   = 16'b0000000001000000,
      S_UWD   = 16'b0000000010000000,
      S_SCAN  = 16'b0000000100000000,
      S_FETCH = 16'b0000001000000000,
      S_PROD  = 16'b0000010000000000,
      S_D1S   = 16'b0000100000000000,
      S_D1W   = 16'b0001000000000000,
      S_D2S   = 16'b0010000000000000,
      S_D2W   = 16'b0100000000000000,
      S_OUT   = 16'b1000000000000000
   } state_type;

   // configuration
   logic [15:0] period_ff, dur_ff, lfi_ff;
   logic        loop_ff;
   logic [7:0]  cols_ff;
   logic [6:0]  alim_ff;
   logic [47:0] origin_ff, drift_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= 16'd4096;
         dur_ff    <= 16'd4096;
         loop_ff   <= 1'b1;
         lfi_ff    <= '0;
         cols_ff   <= 8'd1;
         alim_ff   <= 7'd64;
         origin_ff <= '0;
         drift_ff  <= '0;
      end else if (csr_we) begin
         unique case (spt_pkg::csr_index_type'(csr_index))
            spt_pkg::CSR_SPAWN_PERIOD:  period_ff <= csr_wdata[15:0];
            spt_pkg::CSR_ANIM_DURATION: dur_ff    <= csr_wdata[15:0];
            spt_pkg::CSR_LOOP_ANIM:     loop_ff   <= csr_wdata[0];
            spt_pkg::CSR_LAST_FRAME:    lfi_ff    <= csr_wdata[15:0];
            spt_pkg::CSR_SHEET_COLUMNS: cols_ff   <= csr_wdata[7:0];
            spt_pkg::CSR_ACTIVE_LIMIT:  alim_ff   <= csr_wdata[6:0];
            spt_pkg::CSR_ORIGIN:        origin_ff <= csr_wdata;
            spt_pkg::CSR_DRIFT:         drift_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   logic [15:0] dur_e;
   logic [7:0]  cols_e;
   logic [CW-1:0] lim;
   assign dur_e  = (dur_ff == '0) ? 16'd1 : dur_ff;
   assign cols_e = (cols_ff == '0) ? 8'd1 : cols_ff;
   assign lim = (CW'(alim_ff) > CW'(spt_pkg::MAX_PARTICLES)) ? CW'(spt_pkg::MAX_PARTICLES)
              : ((alim_ff == '0) ? CW'(1) : CW'(alim_ff));

   // sequencer state
   state_type state_ff, state_in;
   logic [16:0] acc_ff, acc_in;
   logic [CW-1:0] count_ff, count_in, slot_ff, slot_in;
   logic [CW-1:0] upd_ff, upd_in, scan_ff, scan_in, emit_ff, emit_in;
   logic          chk_ff, chk_in;
   logic [IW-1:0] chk_idx_ff, chk_idx_in;
   logic          best_v_ff, best_v_in;
   logic [IW-1:0] best_ff, best_in;
   logic [spt_pkg::DIST_W-1:0] best_d_ff, best_d_in;
   logic [spt_pkg::MAX_PARTICLES-1:0] done_ff, done_in;

   // item registers
   logic [15:0] tick_ff;
   logic signed [15:0] nx_ff, ny_ff, nz_ff;
   logic signed [33:0] off_ff;
   logic [47:0] npos_ff, npos_in;
   logic signed [31:0] prod_ff, prod_in;
   logic signed [spt_pkg::SUM_W-1:0] sum_ff, sum_in;
   logic [31:0] fprod_ff, fprod_in;
   logic [15:0] fidx_ff, fidx_in;
   logic [47:0] opos_ff, opos_in;
   logic [7:0]  ocol_ff, ocol_in;
   logic [15:0] orow_ff, orow_in;
   logic        olast_ff, olast_in;

   // slot memories
   logic [47:0] pos_mem [spt_pkg::MAX_PARTICLES];
   logic [15:0] anim_mem [spt_pkg::MAX_PARTICLES];
   logic [spt_pkg::DIST_W-1:0] dist_mem [spt_pkg::MAX_PARTICLES];
   logic [47:0] pos_q;
   logic [15:0] anim_q;
   logic [spt_pkg::DIST_W-1:0] dist_q;
   logic          pa_we, d_we;
   logic [IW-1:0] pa_wa, pa_ra, d_wa, d_ra;
   logic [47:0]   pos_wd;
   logic [15:0]   anim_wd;
   logic [spt_pkg::DIST_W-1:0] dist_wd;

   always_ff @(posedge clock) begin
      if (pa_we) begin
         pos_mem[pa_wa]  <= pos_wd;
         anim_mem[pa_wa] <= anim_wd;
      end
      pos_q  <= pos_mem[pa_ra];
      anim_q <= anim_mem[pa_ra];
      if (d_we) dist_mem[d_wa] <= dist_wd;
      dist_q <= dist_mem[d_ra];
   end

   spt_pkg::div_req_type div_req;
   spt_pkg::div_rsp_type div_rsp;
   spt_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic signed [16:0] s;
      s = 17'($signed(a)) + 17'($signed(b));
      if (s > 17'sd32767) return 16'h7FFF;
      else if (s < -17'sd32768) return 16'h8000;
      else return s[15:0];
   endfunction

   logic [17:0] acc_sum;
   logic [16:0] acc_sat;
   logic [CW-1:0] count_c, slot_w;
   logic [16:0] t_sum, t_new;
   logic [15:0] t_sat;
   logic [47:0] npos_c;
   logic signed [spt_pkg::SUM_W-1:0] abs_sum;
   logic better;

   always_comb begin
      acc_sum = 18'(acc_ff) + 18'(tick_ff);
      acc_sat = (acc_sum > 18'd131071) ? 17'd131071 : acc_sum[16:0];
      count_c = (count_ff > lim) ? lim : count_ff;
      slot_w  = (slot_ff >= lim) ? '0 : slot_ff;

      npos_c = {sat_add(pos_q[47:32], drift_ff[47:32]),
                sat_add(pos_q[31:16], drift_ff[31:16]),
                sat_add(pos_q[15:0], drift_ff[15:0])};
      t_sum = 17'(anim_q) + 17'(tick_ff);
      t_new = t_sum;
      if (t_sum > 17'(dur_e)) t_new = loop_ff ? 17'(t_sum - 17'(dur_e)) : 17'(dur_e);
      t_sat = (t_new > 17'd65535) ? 16'hFFFF : t_new[15:0];

      abs_sum = sum_ff[spt_pkg::SUM_W-1] ? -sum_ff : sum_ff;
      better  = !done_ff[chk_idx_ff] && (!best_v_ff || dist_q > best_d_ff);

      state_in   = state_ff;
      acc_in     = acc_ff;
      count_in   = count_ff;
      slot_in    = slot_ff;
      upd_in     = upd_ff;
      scan_in    = scan_ff;
      emit_in    = emit_ff;
      chk_in     = 1'b0;
      chk_idx_in = chk_idx_ff;
      best_v_in  = best_v_ff;
      best_in    = best_ff;
      best_d_in  = best_d_ff;
      done_in    = done_ff;
      npos_in    = npos_ff;
      prod_in    = prod_ff;
      sum_in     = sum_ff;
      fprod_in   = fprod_ff;
      fidx_in    = fidx_ff;
      opos_in    = opos_ff;
      ocol_in    = ocol_ff;
      orow_in    = orow_ff;
      olast_in   = olast_ff;
      pa_we      = 1'b0;
      pa_wa      = upd_ff[IW-1:0];
      pa_ra      = upd_ff[IW-1:0];
      pos_wd     = npos_c;
      anim_wd    = t_sat;
      d_we       = 1'b0;
      d_wa       = upd_ff[IW-1:0];
      d_ra       = scan_ff[IW-1:0];
      dist_wd    = abs_sum[spt_pkg::DIST_W-1:0];
      div_req    = '0;

      unique case (state_ff)
         S_IDLE: if (req_valid) state_in = S_SPAWN;
         S_SPAWN: begin
            acc_in   = acc_sat;
            count_in = count_c;
            done_in  = '0;
            upd_in   = '0;
            emit_in  = '0;
            if (acc_sat > 17'(period_ff)) begin
               acc_in = 17'(acc_sat - 17'(period_ff));
               if (count_c < lim) count_in = count_c + CW'(1);
               pa_we   = 1'b1;
               pa_wa   = slot_w[IW-1:0];
               pos_wd  = origin_ff;
               anim_wd = '0;
               slot_in = slot_w + CW'(1);
            end
            state_in = (count_in == '0) ? S_IDLE : S_URD;
         end
         S_URD: state_in = S_UMX;
         S_UMX: begin
            pa_we    = 1'b1;
            npos_in  = npos_c;
            prod_in  = nx_ff * $signed(npos_c[15:0]);
            state_in = S_UMY;
         end
         S_UMY: begin
            sum_in   = spt_pkg::SUM_W'(prod_ff);
            prod_in  = ny_ff * $signed(npos_ff[31:16]);
            state_in = S_UMZ;
         end
         S_UMZ: begin
            sum_in   = sum_ff + spt_pkg::SUM_W'(prod_ff);
            prod_in  = nz_ff * $signed(npos_ff[47:32]);
            state_in = S_UMD;
         end
         S_UMD: begin
            sum_in   = sum_ff + spt_pkg::SUM_W'(prod_ff) - spt_pkg::SUM_W'(off_ff);
            state_in = S_UWD;
         end
         S_UWD: begin
            d_we   = 1'b1;
            upd_in = upd_ff + CW'(1);
            if (upd_in == count_ff) begin
               state_in  = S_SCAN;
               scan_in   = '0;
               best_v_in = 1'b0;
            end else begin
               state_in = S_URD;
            end
         end
         S_SCAN: begin
            if (chk_ff && better) begin
               best_v_in = 1'b1;
               best_in   = chk_idx_ff;
               best_d_in = dist_q;
            end
            if (scan_ff < count_ff) begin
               chk_in     = 1'b1;
               chk_idx_in = scan_ff[IW-1:0];
               scan_in    = scan_ff + CW'(1);
            end else if (!chk_ff) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            pa_ra            = best_ff;
            done_in[best_ff] = 1'b1;
            state_in         = S_PROD;
         end
         S_PROD: begin
            opos_in  = pos_q;
            fprod_in = 32'(anim_q) * 32'(lfi_ff);
            state_in = S_D1S;
         end
         S_D1S: begin
            div_req.start    = 1'b1;
            div_req.dividend = fprod_ff;
            div_req.divisor  = dur_e;
            state_in         = S_D1W;
         end
         S_D1W: if (div_rsp.done) begin
            fidx_in  = (div_rsp.quot > 32'd65535) ? 16'hFFFF : div_rsp.quot[15:0];
            state_in = S_D2S;
         end
         S_D2S: begin
            div_req.start    = 1'b1;
            div_req.dividend = 32'(fidx_ff);
            div_req.divisor  = 16'(cols_e);
            state_in         = S_D2W;
         end
         S_D2W: if (div_rsp.done) begin
            ocol_in  = div_rsp.rem[7:0];
            orow_in  = div_rsp.quot[15:0];
            olast_in = (emit_ff + CW'(1)) == count_ff;
            state_in = S_OUT;
         end
         S_OUT: if (!rsp_stall) begin
            emit_in = emit_ff + CW'(1);
            if (olast_ff) begin
               state_in = S_IDLE;
            end else begin
               state_in  = S_SCAN;
               scan_in   = '0;
               best_v_in = 1'b0;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         acc_ff    <= '0;
         count_ff  <= '0;
         slot_ff   <= '0;
         upd_ff    <= '0;
         scan_ff   <= '0;
         emit_ff   <= '0;
         chk_ff    <= 1'b0;
         best_v_ff <= 1'b0;
         done_ff   <= '0;
      end else begin
         state_ff  <= state_in;
         acc_ff    <= acc_in;
         count_ff  <= count_in;
         slot_ff   <= slot_in;
         upd_ff    <= upd_in;
         scan_ff   <= scan_in;
         emit_ff   <= emit_in;
         chk_ff    <= chk_in;
         best_v_ff <= best_v_in;
         done_ff   <= done_in;
      end
      chk_idx_ff <= chk_idx_in;
      best_ff    <= best_in;
      best_d_ff  <= best_d_in;
      npos_ff    <= npos_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      fprod_ff   <= fprod_in;
      fidx_ff    <= fidx_in;
      opos_ff    <= opos_in;
      ocol_ff    <= ocol_in;
      orow_ff    <= orow_in;
      olast_ff   <= olast_in;
      if (state_ff == S_IDLE && req_valid) begin
         tick_ff <= req_tick_time;
         nx_ff   <= req_normal_x;
         ny_ff   <= req_normal_y;
         nz_ff   <= req_normal_z;
         off_ff  <= req_plane_offset;
      end
   end

   assign req_stall        = state_ff != S_IDLE;
   assign rsp_valid        = state_ff == S_OUT;
   assign rsp_pos_x        = opos_ff[15:0];
   assign rsp_pos_y        = opos_ff[31:16];
   assign rsp_pos_z        = opos_ff[47:32];
   assign rsp_sprite_col   = ocol_ff;
   assign rsp_sprite_row   = orow_ff;
   assign rsp_last_of_tick = olast_ff;

`ifndef ASSERT_OFF
   a_emit_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (emit_ff < count_ff))
      else $error("result emitted beyond live count");
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_rsp.busy)
      else $error("divider started while busy");
   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last_of_tick) |=> !req_stall)
      else $error("block not idle after final item of tick");
`endif
endmodule
